// ===== src/uq_pkg.sv =====
package uq_pkg;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_PEEK     = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] tag_value;
    logic [7:0]  position;
  } uq_in_t;

  typedef struct packed {
    logic [31:0] tag_out;
    logic [2:0]  status;
    logic        found;
    logic [8:0]  entry_count;
    logic        is_empty;
    logic        is_full;
  } uq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PEEK,
    S_TAKE,
    S_MOVE,
    S_RESULT
  } uq_state_t;

endpackage

// ===== src/uq_chan_if.sv =====
interface uq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/unique_entry_queue.sv =====
// Channel   Direction  Fields
// in_chan   sink       opcode, tag_value, position
// out_chan  source     tag_out, status, found, entry_count, is_empty, is_full
//
// One compare unit and one two-port store serve every operation, one entry per cycle.
// Insert and contains scan from the head; remove moves each later entry down one
// place, pop being remove at position zero; peek reads the one entry. Clear, range
// and zero-tag refusals and unused opcodes skip to the result. Reset empties the queue.
// A new item is taken while the previous result still waits on a stalled out_chan.
module unique_entry_queue
  import uq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TAG_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  uq_chan_if.sink   in_chan,
  uq_chan_if.source out_chan
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  uq_state_t state_r, state_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [2:0]           op_r, op_nxt;
  logic [TAG_WIDTH-1:0] key_r, key_nxt;
  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic [2:0]           status_r, status_nxt;
  logic                 found_r, found_nxt;
  uq_out_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [TAG_WIDTH-1:0] wdata, rdata;
  logic [63:0]          tag_in_wide, tag_out_wide;
  logic [TAG_WIDTH-1:0] tag_in;
  logic [CW-1:0]        nxt1;
  logic [CW:0]          nxt2;
  logic                 pos_bad;

  uq_ram #(.WIDTH(TAG_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tag_in_wide  = {32'd0, in_chan.payload.tag_value};
  assign tag_in       = tag_in_wide[TAG_WIDTH-1:0];
  assign tag_out_wide = 64'(tag_r);
  assign nxt1         = CW'(idx_r) + CW'(1);
  assign nxt2         = (CW+1)'(idx_r) + (CW+1)'(2);
  assign pos_bad      = 9'(in_chan.payload.position) >= 9'(occ_r);

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    tag_nxt       = tag_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rdata;
    raddr         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt     = in_chan.payload.opcode;
          key_nxt    = tag_in;
          tag_nxt    = '0;
          status_nxt = ST_OK;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_RESULT;
          unique case (in_chan.payload.opcode)
            OP_INSERT: begin
              if (tag_in == '0) begin
                status_nxt = ST_ZERO;
              end else if (occ_r == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = tag_in;
                occ_nxt = CW'(1);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_CONTAINS: begin
              if (tag_in != '0 && occ_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            OP_POP: begin
              if (occ_r == '0) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_TAKE;
              end
            end
            OP_PEEK: begin
              if (pos_bad) begin
                status_nxt = ST_RANGE;
              end else begin
                raddr     = in_chan.payload.position[AW-1:0];
                state_nxt = S_PEEK;
              end
            end
            OP_REMOVE: begin
              if (pos_bad) begin
                status_nxt = ST_RANGE;
              end else begin
                raddr     = in_chan.payload.position[AW-1:0];
                idx_nxt   = in_chan.payload.position[AW-1:0];
                state_nxt = S_TAKE;
              end
            end
            OP_CLEAR: begin
              occ_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rdata == key_r) begin
          if (op_r == OP_INSERT) begin
            status_nxt = ST_DUP;
          end else begin
            found_nxt = 1'b1;
          end
          state_nxt = S_RESULT;
        end else if (nxt1 < occ_r) begin
          raddr   = nxt1[AW-1:0];
          idx_nxt = nxt1[AW-1:0];
        end else begin
          state_nxt = S_RESULT;
          if (op_r == OP_INSERT) begin
            if (occ_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = occ_r[AW-1:0];
              wdata   = key_r;
              occ_nxt = occ_r + CW'(1);
            end
          end
        end
      end

      S_PEEK: begin
        tag_nxt   = rdata;
        state_nxt = S_RESULT;
      end

      S_TAKE: begin
        tag_nxt = rdata;
        if (nxt1 < occ_r) begin
          raddr     = nxt1[AW-1:0];
          state_nxt = S_MOVE;
        end else begin
          occ_nxt   = occ_r - CW'(1);
          state_nxt = S_RESULT;
        end
      end

      S_MOVE: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = rdata;
        idx_nxt = nxt1[AW-1:0];
        if (nxt2 < (CW+1)'(occ_r)) begin
          raddr = nxt2[AW-1:0];
        end else begin
          occ_nxt   = occ_r - CW'(1);
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt.tag_out     = tag_out_wide[31:0];
          out_nxt.status      = status_r;
          out_nxt.found       = found_r;
          out_nxt.entry_count = 9'(occ_r);
          out_nxt.is_empty    = (occ_r == '0);
          out_nxt.is_full     = (occ_r == CW'(DEPTH));
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// ===== src/uq_ram.sv =====
module uq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/unique_entry_queue_tb.sv =====
`timescale 1ns / 1ps

module unique_entry_queue_tb;
  import uq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam int MODE_MIXED = 0;
  localparam int MODE_FILL = 1;
  localparam int MODE_DRAIN = 2;

  typedef struct {
    uq_in_t  item;
    bit      fixed;
    uq_out_t want;
  } step_row_t;

  logic clk;
  logic rst_n;

  uq_chan_if #(.payload_t(uq_in_t)) in_chan ();
  uq_chan_if #(.payload_t(uq_out_t)) out_chan ();

  unique_entry_queue #(
    .DEPTH(QDEPTH),
    .TAG_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  logic [31:0] held_tags[$];
  uq_out_t awaited_results[$];
  logic [31:0] tag_pool[24];
  int error_count;
  int mismatch_count;
  int sender_calm;

  always #10 clk = ~clk;

  function automatic uq_in_t mk_in(logic [2:0] op, logic [31:0] t, logic [7:0] pos);
    uq_in_t it;
    it.opcode = op;
    it.tag_value = t;
    it.position = pos;
    return it;
  endfunction

  function automatic uq_out_t mk_out(logic [31:0] t, logic [2:0] s, bit f, int c,
                                     bit e, bit fu);
    uq_out_t r;
    r.tag_out = t;
    r.status = s;
    r.found = f;
    r.entry_count = 9'(c);
    r.is_empty = e;
    r.is_full = fu;
    return r;
  endfunction

  function automatic bit tag_held(logic [31:0] t);
    foreach (held_tags[i]) begin
      if (held_tags[i] == t) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic uq_out_t next_queue_result(uq_in_t it);
    uq_out_t r;
    r = '0;
    r.status = ST_OK;
    case (it.opcode)
      OP_INSERT: begin
        if (it.tag_value == '0) r.status = ST_ZERO;
        else if (tag_held(it.tag_value)) r.status = ST_DUP;
        else if (held_tags.size() >= QDEPTH) r.status = ST_FULL;
        else held_tags.push_back(it.tag_value);
      end
      OP_POP: begin
        if (held_tags.size() == 0) r.status = ST_RANGE;
        else r.tag_out = held_tags.pop_front();
      end
      OP_PEEK: begin
        if (int'(it.position) >= held_tags.size()) r.status = ST_RANGE;
        else r.tag_out = held_tags[it.position];
      end
      OP_REMOVE: begin
        if (int'(it.position) >= held_tags.size()) begin
          r.status = ST_RANGE;
        end else begin
          r.tag_out = held_tags[it.position];
          held_tags.delete(int'(it.position));
        end
      end
      OP_CONTAINS: r.found = (it.tag_value != '0) && tag_held(it.tag_value);
      OP_CLEAR: held_tags.delete();
      default: ;
    endcase
    r.entry_count = 9'(held_tags.size());
    r.is_empty = (held_tags.size() == 0);
    r.is_full = (held_tags.size() >= QDEPTH);
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic string show(uq_out_t r);
    return $sformatf("tag=%h status=%0d found=%0b count=%0d empty=%0b full=%0b",
                     r.tag_out, r.status, r.found, r.entry_count, r.is_empty, r.is_full);
  endfunction

  function automatic logic [2:0] pick_op(int mode);
    int r;
    int ins;
    r = $urandom_range(0, 99);
    ins = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 10 : 30;
    if (r < ins) return OP_INSERT;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_POP;
    if (r < 40) return OP_PEEK;
    if (r < 62) return OP_REMOVE;
    if (r < 90) return OP_CONTAINS;
    if (r < 92) return OP_CLEAR;
    if (r < 96) return OP_UNUSED_LO;
    return OP_UNUSED_HI;
  endfunction

  function automatic logic [31:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 78) return tag_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  task automatic issue_item(uq_in_t it, bit fixed, uq_out_t want);
    int gap;
    uq_out_t predicted;
    if (sender_calm > 0) begin
      sender_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 2) sender_calm = 40;
      gap = idle_len();
    end
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.payload <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predicted = next_queue_result(it);
    awaited_results.push_back(fixed ? want : predicted);
  endtask

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
          quiet = 0;
        end else begin
          quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                   quiet, awaited_results.size());
          $display("unique_entry_queue_tb: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int stall_left;
    int calm_left;
    uq_out_t got;
    uq_out_t want;
    string bad;
    out_chan.ready = 1'b0;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got = out_chan.payload;
        if (awaited_results.size() == 0) begin
          error_count++;
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) $display("unexpected result: %s", show(got));
        end else begin
          want = awaited_results.pop_front();
          bad = "";
          if (got.tag_out !== want.tag_out) bad = {bad, " tag_out"};
          if (got.status !== want.status) bad = {bad, " status"};
          if (got.found !== want.found) bad = {bad, " found"};
          if (got.entry_count !== want.entry_count) bad = {bad, " entry_count"};
          if (got.is_empty !== want.is_empty) bad = {bad, " is_empty"};
          if (got.is_full !== want.is_full) bad = {bad, " is_full"};
          if (bad != "") begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("mismatch in%s: expected %s, got %s", bad, show(want), show(got));
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 3) calm_left = 50;
        else stall_left = idle_len();
      end
    end
  end

  initial begin
    step_row_t plan[$];
    uq_in_t it;
    int mode;
    int r;
    logic [7:0] pos;

    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.payload = '0;
    error_count = 0;
    mismatch_count = 0;
    sender_calm = 0;

    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    tag_pool[0] = 32'h0000_0001;
    tag_pool[1] = 32'hFFFF_FFFF;
    tag_pool[2] = 32'h8000_0000;

    plan.push_back('{mk_in(OP_POP, '0, '0), 1'b1, mk_out('0, ST_RANGE, 0, 0, 1, 0)});
    plan.push_back('{mk_in(OP_REMOVE, '0, 8'hFF), 1'b1, mk_out('0, ST_RANGE, 0, 0, 1, 0)});
    plan.push_back('{mk_in(OP_INSERT, '0, '0), 1'b1, mk_out('0, ST_ZERO, 0, 0, 1, 0)});
    plan.push_back('{mk_in(OP_CONTAINS, '0, '0), 1'b1, mk_out('0, ST_OK, 0, 0, 1, 0)});
    plan.push_back('{mk_in(OP_INSERT, 32'hFFFF_FFFF, '0), 1'b1,
                     mk_out('0, ST_OK, 0, 1, 0, 0)});
    plan.push_back('{mk_in(OP_INSERT, 32'hFFFF_FFFF, '0), 1'b1,
                     mk_out('0, ST_DUP, 0, 1, 0, 0)});
    plan.push_back('{mk_in(OP_UNUSED_LO, 32'h1234_5678, 8'h01), 1'b1,
                     mk_out('0, ST_OK, 0, 1, 0, 0)});
    for (int i = 0; i < QDEPTH - 1; i++) begin
      plan.push_back('{mk_in(OP_INSERT, 32'h1 << i, 8'(i)), 1'b0, '0});
    end
    plan.push_back('{mk_in(OP_INSERT, 32'h8000_0000, '0), 1'b1,
                     mk_out('0, ST_FULL, 0, QDEPTH, 0, 1)});
    plan.push_back('{mk_in(OP_INSERT, 32'h0000_0001, '0), 1'b1,
                     mk_out('0, ST_DUP, 0, QDEPTH, 0, 1)});
    plan.push_back('{mk_in(OP_PEEK, '0, 8'(QDEPTH)), 1'b1,
                     mk_out('0, ST_RANGE, 0, QDEPTH, 0, 1)});
    plan.push_back('{mk_in(OP_REMOVE, '0, 8'd7), 1'b0, '0});
    plan.push_back('{mk_in(OP_CONTAINS, 32'h0000_0004, '0), 1'b0, '0});
    plan.push_back('{mk_in(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF), 1'b1,
                     mk_out('0, ST_OK, 0, 0, 1, 0)});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) issue_item(plan[i].item, plan[i].fixed, plan[i].want);

    mode = MODE_MIXED;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mode = $urandom_range(MODE_MIXED, MODE_DRAIN);
      r = $urandom_range(0, 99);
      if (r < 85) pos = 8'($urandom_range(0, held_tags.size()));
      else pos = 8'($urandom_range(0, 255));
      it = mk_in(pick_op(mode), pick_tag(), pos);
      issue_item(it, 1'b0, '0);
    end
    in_chan.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("unique_entry_queue_tb: PASS");
    end else begin
      $display("unique_entry_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
